/* hdl/cidp_pkg.sv */
// ----------------------------------------------------------------------------
// Copy/insert delta patch parser package
// Shared result codes, parse phases, the result record and the magic table.
// ----------------------------------------------------------------------------
`default_nettype none

package cidp_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_LITERAL = 2'd0;
    localparam logic [1:0] KIND_COPY    = 2'd1;
    localparam logic [1:0] KIND_DONE    = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    // Error codes reported with KIND_ERROR.
    localparam logic [2:0] ERR_MAGIC     = 3'd0;
    localparam logic [2:0] ERR_SRC_SIZE  = 3'd1;
    localparam logic [2:0] ERR_TRUNCATED = 3'd2;
    localparam logic [2:0] ERR_COPY_RNG  = 3'd3;
    localparam logic [2:0] ERR_OPCODE    = 3'd4;
    localparam logic [2:0] ERR_TGT_SIZE  = 3'd5;

    // Record opcodes.
    localparam logic [7:0] OP_COPY = 8'h00;
    localparam logic [7:0] OP_DATA = 8'h01;
    localparam logic [7:0] OP_END  = 8'hFF;

    // Header layout: magic ends at byte 3, source size at 7, target size at 11.
    localparam logic [3:0] HDR_MAGIC_LAST = 4'd3;
    localparam logic [3:0] HDR_SRC_LAST   = 4'd7;
    localparam logic [3:0] HDR_TGT_LAST   = 4'd11;
    // Operand layout: COPY offset ends at byte 3, its length at byte 7.
    localparam logic [3:0] OPND_WORD0_LAST = 4'd3;
    localparam logic [3:0] OPND_WORD1_LAST = 4'd7;

    // Saturation limit of the running output total.
    localparam logic [32:0] TOTAL_CAP = {1'b1, 32'h0000_0000};

    typedef enum logic [5:0] {
        PH_HEADER     = 6'b000001,
        PH_OPCODE     = 6'b000010,
        PH_COPY       = 6'b000100,
        PH_DATA_LEN   = 6'b001000,
        PH_DATA_BYTES = 6'b010000,
        PH_DRAIN      = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  literal_byte;
        logic [31:0] copy_offset;
        logic [31:0] copy_length;
        logic [2:0]  error_code;
    } t_result;

    // Expected magic byte at a header position.
    function automatic logic [7:0] cidp_magic(input logic [1:0] idx);
        logic [7:0] v;
        unique case (idx)
            2'd0: v = 8'h47;
            2'd1: v = 8'h45;
            2'd2: v = 8'h50;
            2'd3: v = 8'h31;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* hdl/cidp_parser.sv */
// ----------------------------------------------------------------------------
// Delta patch byte parser
// Holds the parse state and turns each accepted byte into at most one result.
// ----------------------------------------------------------------------------
`default_nettype none

module cidp_parser
    import cidp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic [7:0]  i_patch_byte,
    input  wire logic        i_is_last,
    input  wire logic [31:0] i_source_length,
    output logic             o_push,
    output t_result          o_result
);

    t_phase      r_phase, n_phase;
    logic [3:0]  r_pos, n_pos;
    logic [32:0] r_total, n_total;
    logic [31:0] r_word, n_word;
    logic [31:0] r_offset, n_offset;
    logic [31:0] r_remain, n_remain;
    logic [31:0] r_target, n_target;

    logic [31:0] w_word_in;
    logic [33:0] w_total_sum;
    logic [32:0] w_copy_end;
    logic [31:0] w_remain_dec;
    logic        w_add;
    logic        w_err;
    logic [2:0]  w_err_code;
    logic        w_emit;
    t_result     w_emit_res;

    assign w_word_in    = {i_patch_byte, r_word[31:8]};
    assign w_total_sum  = {1'b0, r_total} + {2'b00, w_word_in};
    assign w_copy_end   = {1'b0, r_offset} + {1'b0, w_word_in};
    assign w_remain_dec = (r_remain != 32'd0) ? r_remain - 32'd1 : 32'd0;

    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_word     = r_word;
        n_offset   = r_offset;
        n_remain   = r_remain;
        n_target   = r_target;
        w_add      = 1'b0;
        w_err      = 1'b0;
        w_err_code = ERR_MAGIC;
        w_emit     = 1'b0;
        w_emit_res = '0;

        unique case (r_phase)
            PH_HEADER: begin
                if (r_pos <= HDR_MAGIC_LAST) begin
                    if (i_patch_byte != cidp_magic(r_pos[1:0])) begin
                        w_err      = 1'b1;
                        w_err_code = ERR_MAGIC;
                    end
                end else begin
                    n_word = w_word_in;
                    if (r_pos == HDR_SRC_LAST && w_word_in != i_source_length) begin
                        w_err      = 1'b1;
                        w_err_code = ERR_SRC_SIZE;
                    end
                    if (r_pos == HDR_TGT_LAST) begin
                        n_target = w_word_in;
                        n_phase  = PH_OPCODE;
                    end
                end
                n_pos = r_pos + 4'd1;
                if (!w_err && i_is_last) begin
                    w_err      = 1'b1;
                    w_err_code = ERR_TRUNCATED;
                end
            end
            PH_OPCODE: begin
                n_pos = 4'd0;
                priority if (i_patch_byte == OP_COPY) begin
                    n_phase = PH_COPY;
                    if (i_is_last) begin
                        w_err      = 1'b1;
                        w_err_code = ERR_TRUNCATED;
                    end
                end else if (i_patch_byte == OP_DATA) begin
                    n_phase = PH_DATA_LEN;
                    if (i_is_last) begin
                        w_err      = 1'b1;
                        w_err_code = ERR_TRUNCATED;
                    end
                end else if (i_patch_byte == OP_END) begin
                    if (r_total == {1'b0, r_target}) begin
                        w_emit          = 1'b1;
                        w_emit_res.kind = KIND_DONE;
                    end else begin
                        w_err      = 1'b1;
                        w_err_code = ERR_TGT_SIZE;
                    end
                    n_phase = PH_DRAIN;
                end else begin
                    w_err      = 1'b1;
                    w_err_code = ERR_OPCODE;
                end
            end
            PH_COPY: begin
                n_word = w_word_in;
                n_pos  = r_pos + 4'd1;
                priority if (r_pos == OPND_WORD0_LAST) begin
                    n_offset = w_word_in;
                    if (i_is_last) begin
                        w_err      = 1'b1;
                        w_err_code = ERR_TRUNCATED;
                    end
                end else if (r_pos >= OPND_WORD1_LAST) begin
                    priority if (w_copy_end > {1'b0, i_source_length}) begin
                        w_err      = 1'b1;
                        w_err_code = ERR_COPY_RNG;
                    end else if (i_is_last) begin
                        w_err      = 1'b1;
                        w_err_code = ERR_TRUNCATED;
                    end else begin
                        w_emit                 = 1'b1;
                        w_emit_res.kind        = KIND_COPY;
                        w_emit_res.copy_offset = r_offset;
                        w_emit_res.copy_length = w_word_in;
                        w_add                  = 1'b1;
                        n_phase                = PH_OPCODE;
                    end
                end else if (i_is_last) begin
                    w_err      = 1'b1;
                    w_err_code = ERR_TRUNCATED;
                end
            end
            PH_DATA_LEN: begin
                n_word = w_word_in;
                n_pos  = r_pos + 4'd1;
                if (r_pos >= OPND_WORD0_LAST) begin
                    w_add = 1'b1;
                    priority if (i_is_last) begin
                        w_err      = 1'b1;
                        w_err_code = ERR_TRUNCATED;
                    end else if (w_word_in == 32'd0) begin
                        n_phase = PH_OPCODE;
                    end else begin
                        n_remain = w_word_in;
                        n_phase  = PH_DATA_BYTES;
                    end
                end else if (i_is_last) begin
                    w_err      = 1'b1;
                    w_err_code = ERR_TRUNCATED;
                end
            end
            PH_DATA_BYTES: begin
                n_remain = w_remain_dec;
                if (i_is_last) begin
                    w_err      = 1'b1;
                    w_err_code = ERR_TRUNCATED;
                end else begin
                    w_emit                  = 1'b1;
                    w_emit_res.kind         = KIND_LITERAL;
                    w_emit_res.literal_byte = i_patch_byte;
                    if (w_remain_dec == 32'd0) begin
                        n_phase = PH_OPCODE;
                    end
                end
            end
            PH_DRAIN: begin
            end
            default: begin
                n_phase = PH_DRAIN;
            end
        endcase

        // Saturating running total of bytes the patch produces.
        if (!w_add) begin
            n_total = r_total;
        end else if (w_total_sum > {1'b0, TOTAL_CAP}) begin
            n_total = TOTAL_CAP;
        end else begin
            n_total = w_total_sum[32:0];
        end

        if (w_err) begin
            n_phase = PH_DRAIN;
        end

        // The last byte of a patch always rearms the parser.
        if (i_is_last) begin
            n_phase = PH_HEADER;
            n_pos   = 4'd0;
            n_total = '0;
        end
    end

    always_comb begin
        o_push = i_accept && (w_err || w_emit);
        if (w_err) begin
            o_result            = '0;
            o_result.kind       = KIND_ERROR;
            o_result.error_code = w_err_code;
        end else begin
            o_result = w_emit_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_pos   <= 4'd0;
            r_total <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_word   <= n_word;
            r_offset <= n_offset;
            r_remain <= n_remain;
            r_target <= n_target;
        end
    end

endmodule

`default_nettype wire

/* hdl/copy_insert_delta_patch_parser_unit.sv */
// ----------------------------------------------------------------------------
// Copy/insert delta patch parser unit
// Parses a byte-wide delta patch stream into literal bytes, copy commands and
// a final status, checking the header against the configured source length.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  -------   ---------  -------------------  -----------------------------------
//  input     in         i_valid / o_stall    i_patch_byte, i_is_last
//  output    out        o_valid / i_stall    o_kind, o_literal_byte, o_copy_offset,
//                                            o_copy_length, o_error_code
//  config    in         i_cfg_wr_en          i_cfg_wr_data (source length)
//
// Each byte is parsed in the cycle it is accepted; its result, if any, is
// registered into the result queue, whose head drives the output. One byte
// per cycle is sustained while o_stall is low, limited by the parse state update.
// A two-entry result queue lets the input keep flowing while a result waits;
// o_stall rises only when both entries are full.
// Reset is synchronous and active low; it clears the parse state, the queue
// and the source length register.
//
`default_nettype none

module copy_insert_delta_patch_parser_unit
    import cidp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration.
    input  wire logic        i_cfg_wr_en,
    input  wire logic [31:0] i_cfg_wr_data,
    // Input transactions.
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_patch_byte,
    input  wire logic        i_is_last,
    // Output transactions.
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_literal_byte,
    output logic [31:0]      o_copy_offset,
    output logic [31:0]      o_copy_length,
    output logic [2:0]       o_error_code
);

    logic [31:0] r_source_length;
    logic [1:0]  r_cnt, n_cnt;
    t_result     r_head;
    t_result     r_tail;

    logic        w_accept;
    logic        w_push;
    logic        w_pop;
    t_result     w_result;

    // The user must write the source length register only while the parser is idle; not enforced.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_length <= '0;
        end else if (i_cfg_wr_en) begin
            r_source_length <= i_cfg_wr_data;
        end
    end

    // Input is refused only when both queue entries hold results.
    assign o_stall  = (r_cnt == 2'd2);
    assign w_accept = i_valid && !o_stall;

    cidp_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_patch_byte    (i_patch_byte),
        .i_is_last       (i_is_last),
        .i_source_length (r_source_length),
        .o_push          (w_push),
        .o_result        (w_result)
    );

    // Result queue: the head entry drives the outputs, the tail entry catches a
    // result produced while the head is held by a stalled consumer.
    assign w_pop = (r_cnt != 2'd0) && !i_stall;

    always_comb begin
        n_cnt = r_cnt;
        unique case ({w_push, w_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && r_cnt == 2'd2) begin
            r_head <= r_tail;
        end
        if (w_push) begin
            if (r_cnt == 2'd0 || (r_cnt == 2'd1 && w_pop)) begin
                r_head <= w_result;
            end else begin
                r_tail <= w_result;
            end
        end
    end

    assign o_valid        = (r_cnt != 2'd0);
    assign o_kind         = r_head.kind;
    assign o_literal_byte = r_head.literal_byte;
    assign o_copy_offset  = r_head.copy_offset;
    assign o_copy_length  = r_head.copy_length;
    assign o_error_code   = r_head.error_code;

    // A full queue always presents a result.
    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with an empty result queue");

    // A full queue whose head is held stays full on the next cycle.
    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && i_stall) |=> (r_cnt == 2'd2))
        else $error("result queue lost an entry while stalled");

    // Error results carry only defined error codes.
    a_err_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_ERROR) |-> (o_error_code <= ERR_TGT_SIZE))
        else $error("undefined error code reported");

    // Copy fields are zero on every result that is not a copy command.
    a_copy_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind != KIND_COPY) |-> (o_copy_offset == 32'd0 &&
                                              o_copy_length == 32'd0))
        else $error("copy fields set on a non-copy result");

endmodule

`default_nettype wire

/* verif/copy_insert_delta_patch_parser_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delta patch parser unit test
// Streams patch bytes into the parser and checks every result transaction
// against a cycle-free model of the parse state, kept inside the bench. A
// short set of hand-built patches comes first, followed by random patches
// (mostly well formed, some broken) under several source lengths and several
// mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------

module copy_insert_delta_patch_parser_unit_test;

    import cidp_pkg::*;

    // Run control.
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 4;      // settling wait before a register write and the verdict
    localparam int HOLD_CYCLES   = 300;    // long receiver hold-off

    // Magic bytes in stream order, least significant byte first.
    localparam logic [31:0] MAGIC_WORD = 32'h3150_4547;

    // Ways the random patch builder can break a patch.
    typedef enum int {
        FLT_NONE,
        FLT_MAGIC,
        FLT_SRC_SIZE,
        FLT_TRUNCATE,
        FLT_COPY_RANGE,
        FLT_OPCODE,
        FLT_TARGET,
        FLT_TAIL,
        FLT_NOISE
    } t_fault;

    // One patch byte as it goes onto the input channel.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_beat;

    // ------------------------------------------------------------------------
    // Clock, reset and the ports of the block. Every input starts known.
    // ------------------------------------------------------------------------
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [31:0] i_cfg_wr_data = '0;
    logic        i_valid       = 1'b0;
    logic        o_stall;
    logic [7:0]  i_patch_byte  = '0;
    logic        i_is_last     = 1'b0;
    logic        o_valid;
    logic        i_stall       = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_literal_byte;
    logic [31:0] o_copy_offset;
    logic [31:0] o_copy_length;
    logic [2:0]  o_error_code;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    copy_insert_delta_patch_parser_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_patch_byte   (i_patch_byte),
        .i_is_last      (i_is_last),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_literal_byte (o_literal_byte),
        .o_copy_offset  (o_copy_offset),
        .o_copy_length  (o_copy_length),
        .o_error_code   (o_error_code)
    );

    // ------------------------------------------------------------------------
    // Bench state.
    // ------------------------------------------------------------------------
    t_result     expected_results[$];  // parse results still owed by the block
    t_beat       patch_beats[$];       // the patch being built, in send order
    int          fail_count      = 0;
    int          cycle_count     = 0;
    int          sender_idle_pct = 0;
    int          recv_stall_pct  = 0;
    int          hold_requests   = 0;  // bumped by a test to ask for a hold-off
    int          hold_served     = 0;
    int          hold_left       = 0;

    // Shadow of the parse state. It advances once per accepted byte.
    logic [31:0] src_length;
    t_phase      pp_phase;
    logic [3:0]  pp_pos;
    logic [31:0] pp_word;
    logic [31:0] pp_offset;
    logic [31:0] pp_remaining;
    logic [31:0] pp_target;
    logic [32:0] pp_total;

    // ------------------------------------------------------------------------
    // Parse model.
    // ------------------------------------------------------------------------

    // The running output total saturates at 2^32 so that it can never wrap
    // around onto a small target size.
    function automatic logic [32:0] sat_add(input logic [32:0] acc,
                                            input logic [31:0] amount);
        logic [33:0] sum;
        sum = {1'b0, acc} + {2'b00, amount};
        return (sum > {1'b0, TOTAL_CAP}) ? TOTAL_CAP : sum[32:0];
    endfunction

    // A byte marked last always brings the parser back to the start of a patch.
    function automatic void parse_rearm();
        pp_phase     = PH_HEADER;
        pp_pos       = '0;
        pp_word      = '0;
        pp_offset    = '0;
        pp_remaining = '0;
        pp_target    = '0;
        pp_total     = '0;
    endfunction

    // Advances the shadow state by one accepted byte and queues the result,
    // if the byte causes one.
    function automatic void predict_parse(input logic [7:0] b, input logic last);
        t_result    res;
        logic       emit;
        logic       failed;
        logic [2:0] code;
        logic [3:0] p;
        res    = '0;
        emit   = 1'b0;
        failed = 1'b0;
        code   = ERR_MAGIC;
        p      = pp_pos;
        case (pp_phase)
            PH_HEADER: begin
                if (p <= HDR_MAGIC_LAST) begin
                    if (b != MAGIC_WORD[8*p[1:0] +: 8]) begin
                        failed = 1'b1;
                        code   = ERR_MAGIC;
                    end
                end else begin
                    pp_word = {b, pp_word[31:8]};
                    if (p == HDR_SRC_LAST && pp_word != src_length) begin
                        failed = 1'b1;
                        code   = ERR_SRC_SIZE;
                    end
                    if (p == HDR_TGT_LAST) begin
                        pp_target = pp_word;
                        pp_phase  = PH_OPCODE;
                    end
                end
                pp_pos = p + 4'd1;
                if (!failed && last) begin
                    failed = 1'b1;
                    code   = ERR_TRUNCATED;
                end
            end
            PH_OPCODE: begin
                pp_pos = '0;
                if (b == OP_COPY) begin
                    pp_phase = PH_COPY;
                    if (last) begin
                        failed = 1'b1;
                        code   = ERR_TRUNCATED;
                    end
                end else if (b == OP_DATA) begin
                    pp_phase = PH_DATA_LEN;
                    if (last) begin
                        failed = 1'b1;
                        code   = ERR_TRUNCATED;
                    end
                end else if (b == OP_END) begin
                    if (pp_total == {1'b0, pp_target}) begin
                        res.kind = KIND_DONE;
                        emit     = 1'b1;
                    end else begin
                        failed = 1'b1;
                        code   = ERR_TGT_SIZE;
                    end
                    pp_phase = PH_DRAIN;
                end else begin
                    failed = 1'b1;
                    code   = ERR_OPCODE;
                end
            end
            PH_COPY: begin
                pp_word = {b, pp_word[31:8]};
                pp_pos  = p + 4'd1;
                if (p == OPND_WORD0_LAST) begin
                    pp_offset = pp_word;
                    if (last) begin
                        failed = 1'b1;
                        code   = ERR_TRUNCATED;
                    end
                end else if (p >= OPND_WORD1_LAST) begin
                    // The range check is done in 33 bits, so offset plus
                    // length cannot wrap past the end of the source.
                    if ({1'b0, pp_offset} + {1'b0, pp_word} > {1'b0, src_length}) begin
                        failed = 1'b1;
                        code   = ERR_COPY_RNG;
                    end else if (last) begin
                        failed = 1'b1;
                        code   = ERR_TRUNCATED;
                    end else begin
                        res.kind        = KIND_COPY;
                        res.copy_offset = pp_offset;
                        res.copy_length = pp_word;
                        emit            = 1'b1;
                        pp_total        = sat_add(pp_total, pp_word);
                        pp_phase        = PH_OPCODE;
                    end
                end else if (last) begin
                    failed = 1'b1;
                    code   = ERR_TRUNCATED;
                end
            end
            PH_DATA_LEN: begin
                pp_word = {b, pp_word[31:8]};
                pp_pos  = p + 4'd1;
                if (p >= OPND_WORD0_LAST) begin
                    // The whole literal run counts toward the total up front.
                    pp_total = sat_add(pp_total, pp_word);
                    if (last) begin
                        failed = 1'b1;
                        code   = ERR_TRUNCATED;
                    end else if (pp_word == '0) begin
                        pp_phase = PH_OPCODE;
                    end else begin
                        pp_remaining = pp_word;
                        pp_phase     = PH_DATA_BYTES;
                    end
                end else if (last) begin
                    failed = 1'b1;
                    code   = ERR_TRUNCATED;
                end
            end
            PH_DATA_BYTES: begin
                if (pp_remaining != '0) begin
                    pp_remaining = pp_remaining - 32'd1;
                end
                if (last) begin
                    failed = 1'b1;
                    code   = ERR_TRUNCATED;
                end else begin
                    res.kind         = KIND_LITERAL;
                    res.literal_byte = b;
                    emit             = 1'b1;
                    if (pp_remaining == '0) begin
                        pp_phase = PH_OPCODE;
                    end
                end
            end
            default: begin
                // Draining: the byte is dropped without a result.
            end
        endcase

        if (failed) begin
            res            = '0;
            res.kind       = KIND_ERROR;
            res.error_code = code;
            emit           = 1'b1;
            pp_phase       = PH_DRAIN;
        end
        if (emit) begin
            expected_results.push_back(res);
        end
        if (last) begin
            parse_rearm();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Input side.
    // ------------------------------------------------------------------------

    // Offers one byte, with random gaps ahead of it, and holds it steady until
    // the block takes it. The model is advanced at the accepting edge.
    task automatic send_byte(input logic [7:0] data, input logic last);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_patch_byte <= data;
        i_is_last    <= last;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        predict_parse(data, last);
    endtask

    // Stops offering bytes and waits until every owed result has come out.
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // The register may only change while the parser is idle. Bytes that
    // produce nothing can still be in flight after the last result, so the bench
    // lets them settle before the write.
    task automatic write_source_length(input logic [31:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        src_length = value;
    endtask

    function automatic void add_byte(input logic [7:0] b);
        patch_beats.push_back('{data: b, last: 1'b0});
    endfunction

    function automatic void add_word(input logic [31:0] w);
        for (int k = 0; k < 4; k++) begin
            add_byte(w[8*k +: 8]);
        end
    endfunction

    function automatic void add_header(input logic [31:0] src, input logic [31:0] tgt);
        patch_beats.delete();
        add_word(MAGIC_WORD);
        add_word(src);
        add_word(tgt);
    endfunction

    // Marks the final byte and streams the whole patch.
    task automatic send_patch();
        t_beat tail;
        tail      = patch_beats[patch_beats.size() - 1];
        tail.last = 1'b1;
        patch_beats[patch_beats.size() - 1] = tail;
        foreach (patch_beats[k]) begin
            send_byte(patch_beats[k].data, patch_beats[k].last);
        end
    endtask

    // Builds a random patch against the given source length. Most patches
    // are well formed so that the record phases get real coverage; the rest
    // carry one of the faults above.
    function automatic void build_patch(input logic [31:0] src);
        t_fault      fault;
        t_beat       beat;
        int          n_rec;
        int          bad_rec;
        int          cut;
        logic [32:0] total;
        logic [31:0] tgt;
        logic [31:0] off;
        logic [31:0] len;
        logic [31:0] diff;

        fault = ($urandom_range(99) < 65) ? FLT_NONE : t_fault'($urandom_range(1, 8));
        patch_beats.delete();

        if (fault == FLT_NOISE) begin
            repeat ($urandom_range(1, 24)) add_byte(8'($urandom_range(0, 255)));
        end else begin
            add_word(MAGIC_WORD);
            if (fault == FLT_MAGIC) begin
                cut       = $urandom_range(0, 3);
                beat      = patch_beats[cut];
                beat.data = beat.data ^ 8'($urandom_range(1, 255));
                patch_beats[cut] = beat;
            end
            add_word((fault == FLT_SRC_SIZE) ? (src ^ (32'd1 << $urandom_range(0, 31)))
                                             : src);
            add_word(32'd0);   // target size, patched in once the total is known

            n_rec   = $urandom_range(1, 5);
            bad_rec = $urandom_range(0, n_rec - 1);
            total   = '0;
            for (int r = 0; r < n_rec; r++) begin
                if (fault == FLT_OPCODE && r == bad_rec) begin
                    add_byte(8'($urandom_range(2, 254)));
                end
                if ((fault == FLT_COPY_RANGE && r == bad_rec) || $urandom_range(99) < 40) begin
                    if (fault == FLT_COPY_RANGE && r == bad_rec) begin
                        // Push the end of the copy just past the source end.
                        off  = $urandom_range(0, src);
                        diff = src - off;
                        if (diff > 32'hFFFF_FFEF) begin
                            off  = src;
                            diff = '0;
                        end
                        len = diff + $urandom_range(1, 16);
                    end else begin
                        if ($urandom_range(3) == 0) begin
                            len = $urandom_range(0, src);
                        end else begin
                            len = $urandom_range(0, (src < 32'd64) ? src : 32'd64);
                        end
                        off = $urandom_range(0, src - len);
                    end
                    add_byte(OP_COPY);
                    add_word(off);
                    add_word(len);
                end else begin
                    len = $urandom_range(0, 6);
                    add_byte(OP_DATA);
                    add_word(len);
                    repeat (len) add_byte(8'($urandom_range(0, 255)));
                end
                total = sat_add(total, len);
            end
            add_byte(OP_END);

            tgt = total[32] ? 32'($urandom) : total[31:0];
            if (fault == FLT_TARGET) begin
                tgt = tgt ^ (32'd1 << $urandom_range(0, 31));
            end
            for (int k = 0; k < 4; k++) begin
                beat      = patch_beats[8 + k];
                beat.data = tgt[8*k +: 8];
                patch_beats[8 + k] = beat;
            end

            // Bytes after END are dropped until the last-marked one.
            if (fault == FLT_TAIL) begin
                repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
            end
            // An early last byte can land anywhere: header, opcode, operand
            // or literal.
            if (fault == FLT_TRUNCATE) begin
                cut = $urandom_range(1, patch_beats.size() - 1);
                while (patch_beats.size() > cut) begin
                    void'(patch_beats.pop_back());
                end
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Output side: random stall, the long hold-off, and the result check.
    // ------------------------------------------------------------------------
    task automatic check_result(input t_result got);
        t_result want;
        if (expected_results.size() == 0) begin
            $error("result with nothing expected: kind %0d", got.kind);
            fail_count++;
        end else begin
            want = expected_results.pop_front();
            if (got.kind !== want.kind) begin
                $error("kind: expected %0d, got %0d", want.kind, got.kind);
                fail_count++;
            end
            if (got.literal_byte !== want.literal_byte) begin
                $error("literal_byte: expected %0h, got %0h",
                       want.literal_byte, got.literal_byte);
                fail_count++;
            end
            if (got.copy_offset !== want.copy_offset) begin
                $error("copy_offset: expected %0h, got %0h",
                       want.copy_offset, got.copy_offset);
                fail_count++;
            end
            if (got.copy_length !== want.copy_length) begin
                $error("copy_length: expected %0h, got %0h",
                       want.copy_length, got.copy_length);
                fail_count++;
            end
            if (got.error_code !== want.error_code) begin
                $error("error_code: expected %0d, got %0d",
                       want.error_code, got.error_code);
                fail_count++;
            end
        end
    endtask

    // A result transaction completes at an edge where o_valid is high and
    // i_stall is low. The stall for the next edge is chosen here as well; a
    // pending hold-off request takes over the stall until hold_left runs out.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            check_result('{kind:         o_kind,
                           literal_byte: o_literal_byte,
                           copy_offset:  o_copy_offset,
                           copy_length:  o_copy_length,
                           error_code:   o_error_code});
        end
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            i_stall     <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Header faults, checked with the source length still at its reset value.
    task automatic test_header_checks();
        // A wrong first byte that is also the last one reports the magic
        // error, not truncation.
        patch_beats.delete();
        add_byte(8'h00);
        send_patch();
        // Wrong final magic byte; the byte after it is dropped.
        patch_beats.delete();
        add_word({8'hFF, MAGIC_WORD[23:0]});
        add_byte(8'h12);
        send_patch();
        // Truncated inside the magic.
        patch_beats.delete();
        add_byte(MAGIC_WORD[7:0]);
        send_patch();
        // Source size mismatch on the last byte of its word, then dropped bytes.
        add_header(32'hFFFF_FFFF, 32'd0);
        add_byte(OP_END);
        send_patch();
        // Truncated inside the target size word.
        patch_beats.delete();
        add_word(MAGIC_WORD);
        add_word(32'd0);
        add_byte(8'h00);
        send_patch();
        // An empty patch: header then END with a zero target.
        add_header(32'd0, 32'd0);
        add_byte(OP_END);
        send_patch();
    endtask

    // Every record type and the faults that records can raise.
    task automatic test_records();
        write_source_length(32'h0000_0100);
        // COPY ending exactly at the source end, empty DATA, DATA with the
        // extreme literal values, then END with a matching target.
        add_header(32'h100, 32'h13);
        add_byte(OP_COPY);
        add_word(32'hF0);
        add_word(32'h10);
        add_byte(OP_DATA);
        add_word(32'd0);
        add_byte(OP_DATA);
        add_word(32'd3);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(8'h5A);
        add_byte(OP_END);
        send_patch();
        // COPY one byte past the source end.
        add_header(32'h100, 32'd0);
        add_byte(OP_COPY);
        add_word(32'h80);
        add_word(32'h81);
        send_patch();
        // Unknown opcodes on either side of the valid ones.
        add_header(32'h100, 32'd0);
        add_byte(8'h02);
        send_patch();
        add_header(32'h100, 32'd0);
        add_byte(8'hFE);
        add_byte(OP_END);
        send_patch();
        // Target size mismatch at END.
        add_header(32'h100, 32'd5);
        add_byte(OP_DATA);
        add_word(32'd4);
        add_word(32'hA5C3_0F81);
        add_byte(OP_END);
        send_patch();
        // Last flag on the final byte of a COPY: truncation instead of the copy.
        add_header(32'h100, 32'd1);
        add_byte(OP_COPY);
        add_word(32'd0);
        add_word(32'd1);
        send_patch();
        // Last flag on the final literal: truncation instead of the literal.
        add_header(32'h100, 32'd2);
        add_byte(OP_DATA);
        add_word(32'd2);
        add_byte(8'h3C);
        add_byte(8'hC3);
        send_patch();
        // END not marked last: the bytes after it are dropped.
        add_header(32'h100, 32'd0);
        add_byte(OP_END);
        add_byte(OP_DATA);
        add_byte(8'h77);
        send_patch();
    endtask

    // Full-width operands and the saturating output total.
    task automatic test_saturation();
        write_source_length(32'hFFFF_FFFF);
        // Total reaches exactly the largest target.
        add_header(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_byte(OP_COPY);
        add_word(32'd0);
        add_word(32'hFFFF_FFFF);
        add_byte(OP_COPY);
        add_word(32'hFFFF_FFFF);
        add_word(32'd0);
        add_byte(OP_END);
        send_patch();
        // Total passes 2^32 and sticks there, so no target can match.
        add_header(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_byte(OP_COPY);
        add_word(32'd0);
        add_word(32'hFFFF_FFFF);
        add_byte(OP_COPY);
        add_word(32'd1);
        add_word(32'hFFFF_FFFE);
        add_byte(OP_END);
        send_patch();
        // Offset plus length overflows 32 bits.
        add_header(32'hFFFF_FFFF, 32'd0);
        add_byte(OP_COPY);
        add_word(32'hFFFF_FFFF);
        add_word(32'd1);
        send_patch();
        // Longest literal run, cut short by the last flag.
        add_header(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_byte(OP_DATA);
        add_word(32'hFFFF_FFFF);
        add_byte(8'h81);
        add_byte(8'h7E);
        add_byte(8'h00);
        send_patch();
    endtask

    // The receiver holds off for a long stretch while bytes keep coming, so
    // the result queue fills and the block has to stall its input.
    task automatic test_back_pressure();
        wait_drained();
        sender_idle_pct = 0;
        recv_stall_pct <= 0;
        hold_requests  <= hold_requests + 1;
        add_header(32'hFFFF_FFFF, 32'd48);
        add_byte(OP_DATA);
        add_word(32'd48);
        repeat (48) add_byte(8'($urandom_range(0, 255)));
        add_byte(OP_END);
        send_patch();
    endtask

    // Random patches for one source length and one mix of gaps and stalls.
    // Now and then the sender waits for every owed result before going on.
    task automatic test_random_patches(input int idle_pct, input int stall_pct,
                                       input logic [31:0] src, input int n_bytes);
        int sent;
        sent = 0;
        write_source_length(src);
        sender_idle_pct = idle_pct;
        recv_stall_pct <= stall_pct;
        while (sent < n_bytes) begin
            build_patch(src);
            sent += patch_beats.size();
            send_patch();
            if ($urandom_range(19) == 0) begin
                wait_drained();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence.
    // ------------------------------------------------------------------------
    initial begin
        src_length = '0;
        parse_rearm();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_header_checks();
        test_records();
        test_saturation();
        test_back_pressure();
        test_random_patches(0, 0, 32'd64, 300);
        test_random_patches(80, 0, 32'($urandom), 250);
        test_random_patches(0, 80, 32'hFFFF_FFFF, 250);
        test_random_patches(9, 9, 32'd0, 200);
        test_random_patches(0, 0, 32'($urandom_range(1, 255)), 300);

        // Let any stray result show up before the verdict.
        wait_drained();
        repeat (SETTLE_CYCLES * 4) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/cidp_pkg.sv
hdl/cidp_parser.sv
hdl/copy_insert_delta_patch_parser_unit.sv
verif/copy_insert_delta_patch_parser_unit_test.sv
